// ===== src/hmb_pkg.sv =====
// Package for the heightmap mesh builder.
// Holds the shared constants, the sequencer state type and a small helper function.
// Depends on nothing.
`default_nettype none

package hmb_pkg;

    localparam int MAX_GRID_DEF = 255;
    localparam int HEIGHT_W     = 16;
    localparam int GRID_W       = 8;
    localparam int INDEX_W      = 16;
    localparam int POS_W        = 9;
    localparam int NORM_W       = 16;
    localparam int NORM_FRAC    = 14;
    localparam int MAG_W        = 17;
    localparam int SQ_W         = 34;
    localparam int LEN_W        = 17;
    localparam int NUM_W        = 31;
    localparam int ROW_SLOTS    = 3;

    localparam logic [MAG_W-1:0]  Y_MAG     = MAG_W'(512);
    localparam logic [SQ_W-1:0]   Y_SQ      = SQ_W'(262144);
    localparam logic [SQ_W-1:0]   SQRT_BIT0 = SQ_W'(64'h1_0000_0000);
    localparam logic [NORM_W-1:0] NORM_CAP  = NORM_W'(16384);

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MAG,
        ST_SQX,
        ST_SQZ,
        ST_SUM,
        ST_SQRT,
        ST_DIVPREP,
        ST_DIV,
        ST_VEMIT,
        ST_IEMIT
    } state_t;

    // Slot of a row that lies back rows above the current row, whose slot is cur.
    function automatic logic [1:0] slot_back(input logic [1:0] cur, input logic [1:0] back);
        logic [2:0] s;
        s = {1'b0, cur} + 3'(ROW_SLOTS) - {1'b0, back};
        if (s >= 3'(ROW_SLOTS))
        begin
            s = s - 3'(ROW_SLOTS);
        end
        return s[1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/heightmap_mesh_builder_top.sv =====
// Top level of the heightmap mesh builder: row memory, normal unit and result sequencer.
// Depends on hmb_pkg.
`default_nettype none

// Samples arrive in raster order on the s_axis channel, one height per transfer.
// The grid size register is written through cfg_we/cfg_data; the user must write it only
// while the block is idle (not enforced); each write restarts the mesh at sample (0,0).
// Results leave on m_axis: tdata carries the vertex or corner index record, tuser
// tells vertex from corner index and flags the end of the mesh, tlast marks the
// final result caused by one sample.
// One sample is taken at a time. A sample of row 0 yields no result and leaves the block
// ready. Each vertex record reads the five heights through the single read port of the
// row memory, then runs the magnitude, square and sum steps, 17 square-root steps, three
// quotient runs (one per component; a saturated component skips its run) and the emit
// step. Corner index records follow at one per cycle while the receiver accepts them.
// The output register lets the block take the next sample while the last result
// still waits; when the receiver stalls, the sequencer waits in its emit step.
// Reset clears the counters and sets the grid size to 1. The row memory is not
// cleared; every entry is written before it is read.
module heightmap_mesh_builder_top #(
    parameter int MAX_GRID = hmb_pkg::MAX_GRID_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [7:0]   cfg_data,       // grid_size
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // height[15:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // index[15:0], pos_x[24:16], pos_y[40:25], pos_z[49:41], normal_x[65:50],
    // normal_y[81:66], normal_z[97:82], zero[103:98]
    output logic [103:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser,   // kind[0], mesh_done[1]
    output logic              m_axis_tlast
);

    localparam int ROW_LEN = MAX_GRID + 1;
    localparam int DEPTH   = hmb_pkg::ROW_SLOTS * ROW_LEN;
    localparam int AW      = $clog2(DEPTH);

    localparam int GW = hmb_pkg::GRID_W;

    hmb_pkg::state_t state_reg, state_next;

    logic [GW-1:0] grid_reg;
    logic [GW-1:0] col_reg, row_reg;
    logic [1:0]    slot_reg;
    logic [GW-1:0] n;

    logic [GW-1:0] sx_reg, sz_reg;
    logic [1:0]    sslot_reg;
    logic [2:0]    mask_reg;
    logic          quad_reg, done_reg;
    logic [1:0]    job_reg;
    logic [2:0]    rcnt_reg;
    logic [1:0]    comp_reg;
    logic [3:0]    dcnt_reg;
    logic [2:0]    icnt_reg;

    logic signed [hmb_pkg::HEIGHT_W-1:0] hc_reg, hl_reg, hr_reg, hu_reg, hd_reg;
    logic [hmb_pkg::MAG_W-1:0]  mx_reg, mz_reg;
    logic                       negx_reg, negz_reg;
    logic [hmb_pkg::SQ_W-1:0]   sqa_reg, sqb_reg;
    logic [hmb_pkg::SQ_W-1:0]   sv_reg, sres_reg, sbit_reg;
    logic [hmb_pkg::LEN_W-1:0]  len_reg;
    logic [hmb_pkg::LEN_W-1:0]  rem_reg;
    logic [hmb_pkg::NORM_FRAC-1:0] low_reg;
    logic [hmb_pkg::NORM_FRAC-1:0] quo_reg;
    logic [hmb_pkg::NORM_W-1:0] nrm_reg [3];

    logic [hmb_pkg::HEIGHT_W-1:0] mem [DEPTH];
    logic [hmb_pkg::HEIGHT_W-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] waddr, raddr;

    logic          in_xfer, out_load, more_jobs;
    logic [GW-1:0] vx, vz, rcol, rrow;
    logic [1:0]    rslot;

    logic [hmb_pkg::MAG_W-1:0]  dm;
    logic [hmb_pkg::NUM_W-1:0]  num, lim;
    logic [hmb_pkg::LEN_W:0]    rem_sh;
    logic [hmb_pkg::SQ_W-1:0]   strial;

    logic [GW-1:0]                 ix, iz;
    logic [hmb_pkg::INDEX_W:0]     idx_full;
    logic                          o_kind, o_last, o_done;
    logic [hmb_pkg::POS_W-1:0]     o_px, o_pz;

    logic                          ov_reg, okind_reg, olast_reg, odone_reg;
    logic [hmb_pkg::INDEX_W-1:0]   oidx_reg;
    logic [hmb_pkg::POS_W-1:0]     opx_reg, opz_reg;
    logic [hmb_pkg::HEIGHT_W-1:0]  opy_reg;
    logic [hmb_pkg::NORM_W-1:0]    onx_reg, ony_reg, onz_reg;

    always_comb
    begin
        if (grid_reg == '0)
        begin
            n = GW'(1);
        end
        else if (32'(grid_reg) > MAX_GRID)
        begin
            n = GW'(MAX_GRID);
        end
        else
        begin
            n = grid_reg;
        end
    end

    // Coordinates of the vertex being built.
    always_comb
    begin
        unique case (job_reg)
            2'd0:
            begin
                vx = sx_reg;
                vz = sz_reg - GW'(1);
            end
            2'd1:
            begin
                vx = sx_reg - GW'(1);
                vz = n;
            end
            default:
            begin
                vx = n;
                vz = n;
            end
        endcase
    end

    // Neighbor selection for each read of a vertex.
    always_comb
    begin
        rcol = vx;
        rrow = vz;
        unique case (rcnt_reg)
            3'd1: rcol = (vx == '0) ? vx : vx - GW'(1);
            3'd2: rcol = (vx == n) ? vx : vx + GW'(1);
            3'd3: rrow = (vz == '0) ? vz : vz - GW'(1);
            3'd4: rrow = (vz == n) ? vz : vz + GW'(1);
            default: rrow = vz;
        endcase
        rslot = hmb_pkg::slot_back(sslot_reg, 2'(sz_reg - rrow));
    end

    assign raddr = AW'(rslot) * AW'(ROW_LEN) + AW'(rcol);
    assign waddr = AW'(slot_reg) * AW'(ROW_LEN) + AW'(col_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= s_axis_tdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign more_jobs = (job_reg == 2'd0) ? (mask_reg[1] | mask_reg[2]) :
                       (job_reg == 2'd1) ? mask_reg[2] : 1'b0;

    // Normal arithmetic helpers.
    always_comb
    begin
        unique case (comp_reg)
            2'd0:    dm = mx_reg;
            2'd1:    dm = hmb_pkg::Y_MAG;
            default: dm = mz_reg;
        endcase
        num    = (hmb_pkg::NUM_W'(dm) << hmb_pkg::NORM_FRAC)
               + hmb_pkg::NUM_W'(len_reg >> 1);
        lim    = hmb_pkg::NUM_W'(len_reg) << hmb_pkg::NORM_FRAC;
        rem_sh = {rem_reg, low_reg[hmb_pkg::NORM_FRAC-1]};
        strial = sres_reg + sbit_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hmb_pkg::ST_IDLE:
            begin
                if (in_xfer && row_reg != '0)
                begin
                    state_next = hmb_pkg::ST_READ;
                end
            end
            hmb_pkg::ST_READ:
            begin
                if (rcnt_reg == 3'd5)
                begin
                    state_next = hmb_pkg::ST_MAG;
                end
            end
            hmb_pkg::ST_MAG:  state_next = hmb_pkg::ST_SQX;
            hmb_pkg::ST_SQX:  state_next = hmb_pkg::ST_SQZ;
            hmb_pkg::ST_SQZ:  state_next = hmb_pkg::ST_SUM;
            hmb_pkg::ST_SUM:  state_next = hmb_pkg::ST_SQRT;
            hmb_pkg::ST_SQRT:
            begin
                if (sbit_reg[0])
                begin
                    state_next = hmb_pkg::ST_DIVPREP;
                end
            end
            hmb_pkg::ST_DIVPREP:
            begin
                if (num >= lim)
                begin
                    state_next = (comp_reg == 2'd2) ? hmb_pkg::ST_VEMIT : hmb_pkg::ST_DIVPREP;
                end
                else
                begin
                    state_next = hmb_pkg::ST_DIV;
                end
            end
            hmb_pkg::ST_DIV:
            begin
                if (dcnt_reg == 4'(hmb_pkg::NORM_FRAC - 1))
                begin
                    state_next = (comp_reg == 2'd2) ? hmb_pkg::ST_VEMIT : hmb_pkg::ST_DIVPREP;
                end
            end
            hmb_pkg::ST_VEMIT:
            begin
                if (out_load)
                begin
                    if (more_jobs)
                    begin
                        state_next = hmb_pkg::ST_READ;
                    end
                    else if (quad_reg)
                    begin
                        state_next = hmb_pkg::ST_IEMIT;
                    end
                    else
                    begin
                        state_next = hmb_pkg::ST_IDLE;
                    end
                end
            end
            hmb_pkg::ST_IEMIT:
            begin
                if (out_load && icnt_reg == 3'd5)
                begin
                    state_next = hmb_pkg::ST_IDLE;
                end
            end
            default: state_next = hmb_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        s_axis_tready = (state_reg == hmb_pkg::ST_IDLE);
        in_xfer       = s_axis_tvalid && s_axis_tready;
        mem_we        = in_xfer;
        out_load      = ((state_reg == hmb_pkg::ST_VEMIT) || (state_reg == hmb_pkg::ST_IEMIT))
                        && (!ov_reg || m_axis_tready);
    end

    // Result record assembly.
    always_comb
    begin
        ix = vx;
        iz = vz;
        o_kind = hmb_pkg::KIND_VERTEX;
        o_last = !quad_reg && !more_jobs;
        if (state_reg == hmb_pkg::ST_IEMIT)
        begin
            o_kind = hmb_pkg::KIND_INDEX;
            o_last = (icnt_reg == 3'd5);
            case (icnt_reg)
                3'd1:
                begin
                    ix = sx_reg;
                    iz = sz_reg - GW'(1);
                end
                3'd2, 3'd3:
                begin
                    ix = sx_reg;
                    iz = sz_reg;
                end
                3'd4:
                begin
                    ix = sx_reg - GW'(1);
                    iz = sz_reg;
                end
                default:
                begin
                    ix = sx_reg - GW'(1);
                    iz = sz_reg - GW'(1);
                end
            endcase
        end
        o_done   = o_last && done_reg;
        idx_full = (hmb_pkg::INDEX_W+1)'({1'b0, n} + (GW+1)'(1))
                 * (hmb_pkg::INDEX_W+1)'(iz)
                 + (hmb_pkg::INDEX_W+1)'(ix);
        o_px     = hmb_pkg::POS_W'({1'b0, vx, 1'b0} - {2'b00, n});
        o_pz     = hmb_pkg::POS_W'({2'b00, n} - {1'b0, vz, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hmb_pkg::ST_IDLE;
            grid_reg  <= GW'(1);
            col_reg   <= '0;
            row_reg   <= '0;
            slot_reg  <= '0;
            ov_reg    <= 1'b0;
            rcnt_reg  <= '0;
            comp_reg  <= '0;
            dcnt_reg  <= '0;
            icnt_reg  <= '0;
            job_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                grid_reg <= cfg_data;
                col_reg  <= '0;
                row_reg  <= '0;
                slot_reg <= '0;
            end
            else if (in_xfer)
            begin
                if (col_reg == n)
                begin
                    col_reg <= '0;
                    if (row_reg == n)
                    begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= row_reg + GW'(1);
                        slot_reg <= (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + GW'(1);
                end
            end

            if (in_xfer)
            begin
                job_reg  <= '0;
                rcnt_reg <= '0;
            end
            else if (state_reg == hmb_pkg::ST_READ)
            begin
                rcnt_reg <= rcnt_reg + 3'd1;
            end
            else if (state_reg == hmb_pkg::ST_VEMIT && out_load)
            begin
                rcnt_reg <= '0;
                job_reg  <= (job_reg == 2'd0 && mask_reg[1]) ? 2'd1 : 2'd2;
            end

            if (state_reg == hmb_pkg::ST_SUM)
            begin
                comp_reg <= '0;
            end
            else if ((state_reg == hmb_pkg::ST_DIVPREP && num >= lim)
                     || (state_reg == hmb_pkg::ST_DIV
                         && dcnt_reg == 4'(hmb_pkg::NORM_FRAC - 1)))
            begin
                comp_reg <= comp_reg + 2'd1;
            end

            if (state_reg == hmb_pkg::ST_DIV)
            begin
                dcnt_reg <= dcnt_reg + 4'd1;
            end
            else
            begin
                dcnt_reg <= '0;
            end

            if (in_xfer)
            begin
                icnt_reg <= '0;
            end
            else if (state_reg == hmb_pkg::ST_IEMIT && out_load)
            begin
                icnt_reg <= icnt_reg + 3'd1;
            end

            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sx_reg    <= col_reg;
            sz_reg    <= row_reg;
            sslot_reg <= slot_reg;
            mask_reg  <= {(row_reg == n) && (col_reg == n),
                          (row_reg == n) && (col_reg != '0),
                          (row_reg != '0)};
            quad_reg  <= (row_reg != '0) && (col_reg != '0);
            done_reg  <= (row_reg == n) && (col_reg == n);
        end

        if (state_reg == hmb_pkg::ST_READ)
        begin
            case (rcnt_reg)
                3'd1: hc_reg <= rd_data_reg;
                3'd2: hl_reg <= rd_data_reg;
                3'd3: hr_reg <= rd_data_reg;
                3'd4: hu_reg <= rd_data_reg;
                3'd5: hd_reg <= rd_data_reg;
                default: hc_reg <= hc_reg;
            endcase
        end

        if (state_reg == hmb_pkg::ST_MAG)
        begin
            negx_reg <= (hl_reg < hr_reg);
            negz_reg <= (hd_reg < hu_reg);
            mx_reg   <= (hl_reg < hr_reg)
                      ? hmb_pkg::MAG_W'({hr_reg[15], hr_reg} - {hl_reg[15], hl_reg})
                      : hmb_pkg::MAG_W'({hl_reg[15], hl_reg} - {hr_reg[15], hr_reg});
            mz_reg   <= (hd_reg < hu_reg)
                      ? hmb_pkg::MAG_W'({hu_reg[15], hu_reg} - {hd_reg[15], hd_reg})
                      : hmb_pkg::MAG_W'({hd_reg[15], hd_reg} - {hu_reg[15], hu_reg});
        end

        if (state_reg == hmb_pkg::ST_SQX)
        begin
            sqa_reg <= hmb_pkg::SQ_W'(mx_reg) * hmb_pkg::SQ_W'(mx_reg);
        end
        if (state_reg == hmb_pkg::ST_SQZ)
        begin
            sqb_reg <= hmb_pkg::SQ_W'(mz_reg) * hmb_pkg::SQ_W'(mz_reg);
        end

        if (state_reg == hmb_pkg::ST_SUM)
        begin
            sv_reg   <= sqa_reg + sqb_reg + hmb_pkg::Y_SQ;
            sres_reg <= '0;
            sbit_reg <= hmb_pkg::SQRT_BIT0;
        end
        else if (state_reg == hmb_pkg::ST_SQRT)
        begin
            if (sv_reg >= strial)
            begin
                sv_reg   <= sv_reg - strial;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
            if (sbit_reg[0])
            begin
                len_reg <= (sv_reg >= strial)
                         ? hmb_pkg::LEN_W'((sres_reg >> 1) + sbit_reg)
                         : hmb_pkg::LEN_W'(sres_reg >> 1);
            end
        end

        if (state_reg == hmb_pkg::ST_DIVPREP)
        begin
            rem_reg <= hmb_pkg::LEN_W'(num >> hmb_pkg::NORM_FRAC);
            low_reg <= num[hmb_pkg::NORM_FRAC-1:0];
            quo_reg <= '0;
            if (num >= lim)
            begin
                nrm_reg[comp_reg] <= ((comp_reg == 2'd0 && negx_reg)
                                      || (comp_reg == 2'd2 && negz_reg))
                                   ? -hmb_pkg::NORM_CAP : hmb_pkg::NORM_CAP;
            end
        end
        else if (state_reg == hmb_pkg::ST_DIV)
        begin
            low_reg <= low_reg << 1;
            if (rem_sh >= {1'b0, len_reg})
            begin
                rem_reg <= hmb_pkg::LEN_W'(rem_sh - {1'b0, len_reg});
                quo_reg <= {quo_reg[hmb_pkg::NORM_FRAC-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= hmb_pkg::LEN_W'(rem_sh);
                quo_reg <= {quo_reg[hmb_pkg::NORM_FRAC-2:0], 1'b0};
            end
            if (dcnt_reg == 4'(hmb_pkg::NORM_FRAC - 1))
            begin
                nrm_reg[comp_reg] <= ((comp_reg == 2'd0 && negx_reg)
                                      || (comp_reg == 2'd2 && negz_reg))
                    ? -hmb_pkg::NORM_W'({quo_reg[hmb_pkg::NORM_FRAC-2:0],
                                         rem_sh >= {1'b0, len_reg}})
                    : hmb_pkg::NORM_W'({quo_reg[hmb_pkg::NORM_FRAC-2:0],
                                        rem_sh >= {1'b0, len_reg}});
            end
        end

        if (out_load)
        begin
            okind_reg <= o_kind;
            olast_reg <= o_last;
            odone_reg <= o_done;
            oidx_reg  <= idx_full[hmb_pkg::INDEX_W-1:0];
            if (o_kind == hmb_pkg::KIND_VERTEX)
            begin
                opx_reg <= o_px;
                opy_reg <= hc_reg;
                opz_reg <= o_pz;
                onx_reg <= nrm_reg[0];
                ony_reg <= nrm_reg[1];
                onz_reg <= nrm_reg[2];
            end
            else
            begin
                opx_reg <= '0;
                opy_reg <= '0;
                opz_reg <= '0;
                onx_reg <= '0;
                ony_reg <= '0;
                onz_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = {odone_reg, okind_reg};
    assign m_axis_tdata  = {6'b0, onz_reg, ony_reg, onx_reg, opz_reg, opy_reg, opx_reg, oidx_reg};

    a_mem_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == hmb_pkg::ST_IDLE)
        else $error("row memory written while a sample is in work");

    a_sqrt_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hmb_pkg::ST_SQRT |-> sbit_reg != '0)
        else $error("square root ran past its last step");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("mesh end flagged on a result that is not last");

    a_normal_y: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            !m_axis_tdata[81] && m_axis_tdata[81:66] <= 16'd16384)
        else $error("normal y component out of range");

endmodule

`default_nettype wire

// ===== test/heightmap_mesh_builder_top_tb.sv =====
// Testbench for heightmap_mesh_builder_top: streams height samples in raster order and
// checks every vertex and corner index record against a behavioral mesh predictor.
// Depends on the RTL of the block and on hmb_pkg.
`timescale 1ns / 1ps

module heightmap_mesh_builder_top_tb;

    localparam int IDLE_PCT      = 29;
    localparam int SETTLE_CYCLES = 400;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 150;
    localparam int WIDE_GRID     = 40;

    typedef struct packed {
        logic                               kind;
        logic [hmb_pkg::INDEX_W-1:0]        index;
        logic signed [hmb_pkg::POS_W-1:0]   pos_x;
        logic signed [hmb_pkg::HEIGHT_W-1:0] pos_y;
        logic signed [hmb_pkg::POS_W-1:0]   pos_z;
        logic signed [hmb_pkg::NORM_W-1:0]  normal_x;
        logic signed [hmb_pkg::NORM_W-1:0]  normal_y;
        logic signed [hmb_pkg::NORM_W-1:0]  normal_z;
        logic                               last;
        logic                               mesh_done;
    } mesh_rec_t;

    typedef enum logic { OP_CFG, OP_SAMPLE } step_op_t;

    typedef struct {
        step_op_t    op;
        logic [15:0] value;
        logic        flat;
    } step_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [7:0]   cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    mesh_rec_t    mesh_expected[$];
    int           errors;
    int           quiet_cycles = 0;
    bit           calm;

    int           grid_reg;
    int           col_pos;
    int           row_pos;
    int           heights[hmb_pkg::ROW_SLOTS][hmb_pkg::MAX_GRID_DEF + 1];

    heightmap_mesh_builder_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    function automatic int grid_eff();
        int n;
        n = grid_reg;
        if (n == 0)
        begin
            n = 1;
        end
        if (n > hmb_pkg::MAX_GRID_DEF)
        begin
            n = hmb_pkg::MAX_GRID_DEF;
        end
        return n;
    endfunction

    function automatic int height_at(int c, int r, int n);
        if (c < 0) c = 0;
        if (c > n) c = n;
        if (r < 0) r = 0;
        if (r > n) r = n;
        return heights[r % hmb_pkg::ROW_SLOTS][c];
    endfunction

    function automatic longint floor_root(longint v);
        longint res;
        longint t;
        res = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = res | (longint'(1) << b);
            if (t * t <= v)
            begin
                res = t;
            end
        end
        return res;
    endfunction

    function automatic logic signed [hmb_pkg::NORM_W-1:0] unit_part(longint m, bit neg,
                                                                    longint len);
        longint q;
        q = ((m << hmb_pkg::NORM_FRAC) + len / 2) / len;
        if (q > 16384)
        begin
            q = 16384;
        end
        return neg ? hmb_pkg::NORM_W'(-q) : hmb_pkg::NORM_W'(q);
    endfunction

    function automatic mesh_rec_t vertex_rec(int x, int z, int n);
        mesh_rec_t r;
        longint dx;
        longint dz;
        longint mx;
        longint mz;
        longint len;
        dx = height_at(x - 1, z, n) - height_at(x + 1, z, n);
        dz = height_at(x, z + 1, n) - height_at(x, z - 1, n);
        mx = dx < 0 ? -dx : dx;
        mz = dz < 0 ? -dz : dz;
        len = floor_root(mx * mx + 512 * 512 + mz * mz);
        r.kind      = hmb_pkg::KIND_VERTEX;
        r.index     = hmb_pkg::INDEX_W'((n + 1) * z + x);
        r.pos_x     = hmb_pkg::POS_W'(2 * x - n);
        r.pos_y     = hmb_pkg::HEIGHT_W'(height_at(x, z, n));
        r.pos_z     = hmb_pkg::POS_W'(n - 2 * z);
        r.normal_x  = unit_part(mx, dx < 0, len);
        r.normal_y  = unit_part(512, 1'b0, len);
        r.normal_z  = unit_part(mz, dz < 0, len);
        r.last      = 1'b0;
        r.mesh_done = 1'b0;
        return r;
    endfunction

    function automatic mesh_rec_t corner_rec(int x, int z, int n);
        mesh_rec_t r;
        r = '{default: '0};
        r.kind  = hmb_pkg::KIND_INDEX;
        r.index = hmb_pkg::INDEX_W'((n + 1) * z + x);
        return r;
    endfunction

    task automatic predict_sample(input logic [15:0] h);
        mesh_rec_t recs[$];
        int n;
        int x;
        int z;
        bit wrapped;
        n = grid_eff();
        wrapped = 1'b0;
        if (col_pos > n) col_pos = 0;
        if (row_pos > n) row_pos = 0;
        x = col_pos;
        z = row_pos;
        heights[z % hmb_pkg::ROW_SLOTS][x] = int'($signed(h));
        if (z >= 1)
        begin
            recs.push_back(vertex_rec(x, z - 1, n));
        end
        if (z == n && x >= 1)
        begin
            recs.push_back(vertex_rec(x - 1, n, n));
        end
        if (z == n && x == n)
        begin
            recs.push_back(vertex_rec(n, n, n));
        end
        if (x >= 1 && z >= 1)
        begin
            recs.push_back(corner_rec(x - 1, z - 1, n));
            recs.push_back(corner_rec(x, z - 1, n));
            recs.push_back(corner_rec(x, z, n));
            recs.push_back(corner_rec(x, z, n));
            recs.push_back(corner_rec(x - 1, z, n));
            recs.push_back(corner_rec(x - 1, z - 1, n));
        end
        x++;
        if (x > n)
        begin
            x = 0;
            z++;
            if (z > n)
            begin
                z = 0;
                wrapped = 1'b1;
            end
        end
        col_pos = x;
        row_pos = z;
        if (recs.size() > 0)
        begin
            recs[recs.size() - 1].last = 1'b1;
            recs[recs.size() - 1].mesh_done = wrapped;
        end
        foreach (recs[i])
        begin
            mesh_expected.push_back(recs[i]);
        end
    endtask

    task automatic send_sample(input logic [15:0] h);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predict_sample(h);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (mesh_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_grid(input logic [7:0] g);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= g;
        @(posedge clk);
        cfg_we   <= 1'b0;
        grid_reg = g;
        col_pos  = 0;
        row_pos  = 0;
    endtask

    always @(posedge clk)
    begin
        mesh_rec_t e;
        mesh_rec_t a;
        if (m_axis_tvalid && m_axis_tready)
        begin
            a.kind      = m_axis_tuser[0];
            a.mesh_done = m_axis_tuser[1];
            a.last      = m_axis_tlast;
            a.index     = m_axis_tdata[15:0];
            a.pos_x     = m_axis_tdata[24:16];
            a.pos_y     = m_axis_tdata[40:25];
            a.pos_z     = m_axis_tdata[49:41];
            a.normal_x  = m_axis_tdata[65:50];
            a.normal_y  = m_axis_tdata[81:66];
            a.normal_z  = m_axis_tdata[97:82];
            if (mesh_expected.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, a);
                errors++;
            end
            else
            begin
                e = mesh_expected.pop_front();
                if (a !== e)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, a);
                    errors++;
                end
            end
        end
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        step_t plan[$];
        mesh_rec_t before_cnt;
        int sent;
        int g;
        int first;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        errors        = 0;
        calm          = 1'b0;
        grid_reg      = 1;
        col_pos       = 0;
        row_pos       = 0;
        foreach (heights[r, c])
        begin
            heights[r][c] = 0;
        end

        // Flat ground must give a straight-up normal; the rest is left to the predictor.
        plan = '{
            '{OP_SAMPLE, 16'h0000, 1'b1}, '{OP_SAMPLE, 16'h0000, 1'b1},
            '{OP_SAMPLE, 16'h0000, 1'b1}, '{OP_SAMPLE, 16'h0000, 1'b1},
            '{OP_SAMPLE, 16'h7fff, 1'b0}, '{OP_SAMPLE, 16'h8000, 1'b0},
            '{OP_SAMPLE, 16'h8000, 1'b0}, '{OP_SAMPLE, 16'h7fff, 1'b0},
            '{OP_CFG,    16'h0000, 1'b0},
            '{OP_SAMPLE, 16'h0100, 1'b0}, '{OP_SAMPLE, 16'hff00, 1'b0},
            '{OP_SAMPLE, 16'h0001, 1'b0}, '{OP_SAMPLE, 16'hfffe, 1'b0},
            '{OP_CFG,    16'h0002, 1'b0},
            '{OP_SAMPLE, 16'h8000, 1'b0}, '{OP_SAMPLE, 16'h7fff, 1'b0},
            '{OP_SAMPLE, 16'h0000, 1'b0}, '{OP_SAMPLE, 16'h1234, 1'b0},
            '{OP_SAMPLE, 16'h8000, 1'b0}, '{OP_SAMPLE, 16'h7fff, 1'b0},
            '{OP_SAMPLE, 16'h5555, 1'b0}, '{OP_SAMPLE, 16'haaaa, 1'b0},
            '{OP_SAMPLE, 16'h0000, 1'b0},
            '{OP_CFG,    16'h0003, 1'b0},
            '{OP_SAMPLE, 16'h4000, 1'b0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].op == OP_CFG)
            begin
                write_grid(plan[i].value[7:0]);
            end
            else
            begin
                first = mesh_expected.size();
                send_sample(plan[i].value);
                if (plan[i].flat)
                begin
                    for (int k = first; k < mesh_expected.size(); k++)
                    begin
                        before_cnt = mesh_expected[k];
                        if (before_cnt.kind == hmb_pkg::KIND_VERTEX &&
                            (before_cnt.normal_x !== 16'sd0 ||
                             before_cnt.normal_y !== 16'sd16384 ||
                             before_cnt.normal_z !== 16'sd0))
                        begin
                            $display("%0t: mismatch expected flat normal actual %p",
                                     $time, before_cnt);
                            errors++;
                        end
                    end
                end
            end
        end

        // A wider grid: a full first row and the start of the second, then a restart.
        write_grid(8'(WIDE_GRID));
        for (int i = 0; i < WIDE_GRID + 1 + 9; i++)
        begin
            send_sample(16'($urandom()));
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            g = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
            write_grid(8'(g));
            calm = (sent >= 60 && sent < 110);
            for (int i = 0; i < (grid_eff() + 1) * (grid_eff() + 1); i++)
            begin
                if (i == 3 && $urandom_range(3) == 0)
                begin
                    drain_results();
                end
                if ($urandom_range(3) == 0)
                begin
                    send_sample($urandom_range(1) ? 16'h7fff : 16'h8000);
                end
                else
                begin
                    send_sample(16'($urandom()));
                end
                sent++;
            end
        end
        calm = 1'b0;

        drain_results();
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
